// File: hdl/gcrl_pkg.sv
// shared types and constants of the gradient colour ramp lookup
package gcrl_pkg;

    localparam int unsigned OFF_W  = 17;
    localparam int unsigned CHAN_W = 16;
    localparam int unsigned NCHAN  = 4;
    localparam int unsigned PROD_W = 33;
    localparam int unsigned QBITS  = 16;
    localparam logic [OFF_W-1:0] ONE_Q16 = 17'h10000;

    // function codes
    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_APPEND = 2'd1;
    localparam logic [1:0] FUNC_EVAL   = 2'd2;

    // status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic [1:0]        func;
        logic [OFF_W-1:0]  stop_offset;
        logic [CHAN_W-1:0] stop_red;
        logic [CHAN_W-1:0] stop_green;
        logic [CHAN_W-1:0] stop_blue;
        logic [CHAN_W-1:0] stop_alpha;
        logic [OFF_W-1:0]  sample_pos;
    } in_t;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic [CHAN_W-1:0] out_alpha;
        logic              status;
    } out_t;

    // one colour channel inside the divider
    typedef struct packed {
        logic              neg;
        logic [CHAN_W-1:0] base;
        logic [PROD_W-1:0] num;
        logic [OFF_W-1:0]  rem;
        logic [QBITS-1:0]  quo;
    } lane_t;

    // one divider stage
    typedef struct packed {
        logic                   valid;
        logic                   status;
        logic [OFF_W-1:0]       den;
        lane_t [NCHAN-1:0]      lane;
    } div_stage_t;

endpackage

// File: hdl/gradient_color_ramp_lookup.sv
// top level of the gradient colour ramp lookup
//
//  channel   ports                      direction  payload
//  input     s_valid s_ready s_payload  in         gcrl_pkg::in_t
//  result    m_valid m_ready m_payload  out        gcrl_pkg::out_t
//
// one transaction enters per cycle while s_ready is high; its result is on the m_
// ports once it has passed 20 registers (select, prepare, multiply, 16 divider
// stages, output register), the first loaded at the accepting edge.
// the 16-stage divider, one quotient bit per stage, sets the latency.
// synchronous active-low reset empties the stop table and the pipeline.
// a stalled result holds the whole pipeline; nothing is lost or repeated.
module gradient_color_ramp_lookup #(
    parameter int unsigned MAX_STOPS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  gcrl_pkg::in_t    s_payload,
    output logic             m_valid,
    input  logic             m_ready,
    output gcrl_pkg::out_t   m_payload
);

    localparam int unsigned IDX_W = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_STOPS + 1);
    localparam int unsigned OFF_W = gcrl_pkg::OFF_W;
    localparam int unsigned CW    = gcrl_pkg::CHAN_W;
    localparam int unsigned COL_W = gcrl_pkg::CHAN_W * gcrl_pkg::NCHAN;

    logic en;
    logic acc;

    // stop table
    logic [OFF_W-1:0] off_reg [0:MAX_STOPS-1];
    logic [COL_W-1:0] col_reg [0:MAX_STOPS-1];
    logic [CNT_W-1:0] count_reg;

    assign en      = !m_valid || m_ready;
    assign s_ready = en;
    assign acc     = s_valid && s_ready;

    // table update at acceptance
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (acc) begin
            if (s_payload.func == gcrl_pkg::FUNC_CLEAR) begin
                count_reg <= '0;
            end else if (s_payload.func == gcrl_pkg::FUNC_APPEND &&
                         count_reg < CNT_W'(MAX_STOPS)) begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc && s_payload.func == gcrl_pkg::FUNC_APPEND &&
            count_reg < CNT_W'(MAX_STOPS)) begin
            off_reg[count_reg[IDX_W-1:0]] <= s_payload.stop_offset;
            col_reg[count_reg[IDX_W-1:0]] <= {s_payload.stop_red, s_payload.stop_green,
                                              s_payload.stop_blue, s_payload.stop_alpha};
        end
    end

    // stage 1: pick lower and upper stop
    logic [OFF_W-1:0] pos_c;
    logic [IDX_W-1:0] lo_idx, hi_idx;
    logic             have_lo, have_hi;

    assign pos_c = (s_payload.sample_pos > gcrl_pkg::ONE_Q16) ?
                   gcrl_pkg::ONE_Q16 : s_payload.sample_pos;

    always_comb begin
        lo_idx  = '0;
        hi_idx  = '0;
        have_lo = 1'b0;
        have_hi = 1'b0;
        for (int i = 0; i < MAX_STOPS; i++) begin
            if (CNT_W'(i) < count_reg && !have_hi) begin
                if (pos_c >= off_reg[i]) begin
                    lo_idx  = IDX_W'(i);
                    have_lo = 1'b1;
                end else if (have_lo) begin
                    hi_idx  = IDX_W'(i);
                    have_hi = 1'b1;
                end
            end
        end
        if (!have_hi) begin
            hi_idx = IDX_W'(count_reg - CNT_W'(1));
        end
        if (!have_lo) begin
            lo_idx = '0;
            hi_idx = '0;
        end
    end

    logic             s1_valid_reg, s1_eval_reg, s1_flat_reg, s1_same_reg, s1_status_reg;
    logic [OFF_W-1:0] s1_pos_reg, s1_o0_reg, s1_o1_reg;
    logic [COL_W-1:0] s1_c0_reg, s1_c1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_eval_reg   <= s_payload.func == gcrl_pkg::FUNC_EVAL;
            s1_status_reg <= (s_payload.func == gcrl_pkg::FUNC_APPEND &&
                              count_reg == CNT_W'(MAX_STOPS)) ?
                             gcrl_pkg::STATUS_FULL : gcrl_pkg::STATUS_OK;
            s1_pos_reg    <= pos_c;
            if (count_reg == '0) begin
                // empty table: black to white
                s1_flat_reg <= 1'b0;
                s1_same_reg <= 1'b0;
                s1_o0_reg   <= '0;
                s1_o1_reg   <= gcrl_pkg::ONE_Q16;
                s1_c0_reg   <= {{(COL_W-CW){1'b0}}, {CW{1'b1}}};
                s1_c1_reg   <= '1;
            end else begin
                s1_flat_reg <= !have_lo;
                s1_same_reg <= lo_idx == hi_idx;
                s1_o0_reg   <= off_reg[lo_idx];
                s1_o1_reg   <= off_reg[hi_idx];
                s1_c0_reg   <= col_reg[lo_idx];
                s1_c1_reg   <= col_reg[hi_idx];
            end
        end
    end

    // stage 2: denominator, distance and channel differences
    logic signed [OFF_W+1:0] den_raw;
    logic [OFF_W-1:0]        den_c, t_c;

    always_comb begin
        den_raw = s1_same_reg ?
                  ($signed({2'b00, gcrl_pkg::ONE_Q16}) - $signed({2'b00, s1_o0_reg})) :
                  ($signed({2'b00, s1_o1_reg}) - $signed({2'b00, s1_o0_reg}));
        den_c = (den_raw < 1) ? OFF_W'(1) : den_raw[OFF_W-1:0];
        t_c   = s1_flat_reg ? '0 : OFF_W'(s1_pos_reg - s1_o0_reg);
    end

    logic                                 s2_valid_reg, s2_status_reg;
    logic [OFF_W-1:0]                     s2_den_reg, s2_t_reg;
    logic [gcrl_pkg::NCHAN-1:0]           s2_neg_reg;
    logic [gcrl_pkg::NCHAN-1:0][CW-1:0]   s2_base_reg, s2_mag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        logic [CW-1:0] a, b;
        if (en) begin
            s2_status_reg <= s1_status_reg;
            s2_den_reg    <= den_c;
            s2_t_reg      <= t_c;
            for (int c = 0; c < gcrl_pkg::NCHAN; c++) begin
                a = s1_c0_reg[COL_W-1-CW*c -: CW];
                b = s1_c1_reg[COL_W-1-CW*c -: CW];
                s2_neg_reg[c]  <= b < a;
                s2_base_reg[c] <= s1_eval_reg ? a : '0;
                s2_mag_reg[c]  <= !s1_eval_reg ? '0 : ((b < a) ? a - b : b - a);
            end
        end
    end

    // stage 3: product of difference and distance
    gcrl_pkg::div_stage_t s3_reg, div_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_reg.valid <= 1'b0;
        end else if (en) begin
            s3_reg.valid  <= s2_valid_reg;
            s3_reg.status <= s2_status_reg;
            s3_reg.den    <= s2_den_reg;
            for (int c = 0; c < gcrl_pkg::NCHAN; c++) begin
                s3_reg.lane[c].neg  <= s2_neg_reg[c];
                s3_reg.lane[c].base <= s2_base_reg[c];
                s3_reg.lane[c].num  <= gcrl_pkg::PROD_W'(s2_mag_reg[c]) *
                                       gcrl_pkg::PROD_W'(s2_t_reg);
                s3_reg.lane[c].rem  <= '0;
                s3_reg.lane[c].quo  <= '0;
            end
        end
    end

    // divider input takes the upper numerator bits as the first remainder
    gcrl_pkg::div_stage_t div_in;

    always_comb begin
        div_in = s3_reg;
        for (int c = 0; c < gcrl_pkg::NCHAN; c++) begin
            div_in.lane[c].rem =
                s3_reg.lane[c].num[gcrl_pkg::PROD_W-1 -: gcrl_pkg::OFF_W];
        end
    end

    gcrl_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_stage  (div_in),
        .out_stage (div_out)
    );

    // output register: apply sign of the difference
    logic [gcrl_pkg::NCHAN-1:0][CW-1:0] res;

    always_comb begin
        for (int c = 0; c < gcrl_pkg::NCHAN; c++) begin
            res[c] = div_out.lane[c].neg ?
                     div_out.lane[c].base - div_out.lane[c].quo :
                     div_out.lane[c].base + div_out.lane[c].quo;
        end
    end

    logic           m_valid_reg;
    gcrl_pkg::out_t m_payload_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= div_out.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_payload_reg.out_red   <= res[0];
            m_payload_reg.out_green <= res[1];
            m_payload_reg.out_blue  <= res[2];
            m_payload_reg.out_alpha <= res[3];
            m_payload_reg.status    <= div_out.status;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

// File: hdl/gcrl_divider.sv
// pipelined restoring divider, one quotient bit per stage, four channels
module gcrl_divider (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  gcrl_pkg::div_stage_t   in_stage,
    output gcrl_pkg::div_stage_t   out_stage
);

    gcrl_pkg::div_stage_t st_reg [1:gcrl_pkg::QBITS];

    assign out_stage = st_reg[gcrl_pkg::QBITS];

    genvar k;
    generate
        for (k = 0; k < gcrl_pkg::QBITS; k++) begin : g_step
            gcrl_pkg::div_stage_t st_cur;
            gcrl_pkg::div_stage_t st_next;

            // stage input: divider input or the previous stage
            if (k == 0) begin : g_first
                assign st_cur = in_stage;
            end else begin : g_rest
                assign st_cur = st_reg[k];
            end

            // shift in one numerator bit and try a subtract per channel
            always_comb begin
                logic [gcrl_pkg::OFF_W:0] trial;
                st_next = st_cur;
                for (int c = 0; c < gcrl_pkg::NCHAN; c++) begin
                    trial = {st_cur.lane[c].rem,
                             st_cur.lane[c].num[gcrl_pkg::QBITS-1-k]};
                    if (trial >= {1'b0, st_cur.den}) begin
                        trial = trial - {1'b0, st_cur.den};
                        st_next.lane[c].quo[gcrl_pkg::QBITS-1-k] = 1'b1;
                    end else begin
                        st_next.lane[c].quo[gcrl_pkg::QBITS-1-k] = 1'b0;
                    end
                    st_next.lane[c].rem = trial[gcrl_pkg::OFF_W-1:0];
                end
            end

            // stage register, valid cleared on reset
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    st_reg[k+1].valid <= 1'b0;
                end else if (en) begin
                    st_reg[k+1] <= st_next;
                end
            end
        end
    endgenerate

endmodule
